// File: hw/rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // field widths
  localparam int unsigned HueW  = 9;
  localparam int unsigned PctW  = 7;
  localparam int unsigned ChanW = 8;

  // conversion constants
  localparam int unsigned Circle   = 360;
  localparam int unsigned Sextant  = 60;
  localparam int unsigned PctMax   = 100;
  localparam int unsigned Full     = 255;
  // v numerator is v * 6000 over the common denominator 600000
  localparam int unsigned ValScale = 6000;

  // internal widths
  localparam int unsigned TentW = 6;   // 0..60
  localparam int unsigned SvW   = 14;  // s*v up to 10000
  localparam int unsigned NumW  = 20;  // numerators up to 600000

  // x*255/600000 = x*17/40000 = ((x*17) >> 6) / 625
  localparam int unsigned ScaleMul   = 17;
  localparam int unsigned ScaleShift = 6;
  localparam int unsigned MulW       = 25;
  localparam int unsigned RedW       = MulW - ScaleShift;
  // divide by 625 through a reciprocal, exact for the reduced range
  localparam int unsigned RecipShift = 28;
  localparam int unsigned RecipM     = 429497;
  localparam int unsigned RecipMW    = 19;
  localparam int unsigned ProdW      = RedW + RecipMW;

  // channel lanes
  localparam int unsigned NumCh   = 3;
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,
    SEXT_YG = 3'd1,
    SEXT_GC = 3'd2,
    SEXT_CB = 3'd3,
    SEXT_BM = 3'd4,
    SEXT_MR = 3'd5
  } sextant_e;

  typedef struct packed {
    logic [HueW-1:0] hue;
    logic [PctW-1:0] sat;
    logic [PctW-1:0] val;
  } pix_t;

  typedef struct packed {
    sextant_e         sextant;
    logic [TentW-1:0] tent;
    logic [PctW-1:0]  sat;
    logic [PctW-1:0]  val;
  } dec_t;

  typedef struct packed {
    sextant_e         sextant;
    logic [TentW-1:0] tent;
    logic [SvW-1:0]   sv;
    logic [NumW-1:0]  v_num;
  } prod_t;

  typedef logic [NumCh-1:0][NumW-1:0]  nums_t;
  typedef logic [NumCh-1:0][RedW-1:0]  reds_t;
  typedef logic [NumCh-1:0][ChanW-1:0] chans_t;

endpackage

// File: hw/rtl/hsv2rgb_if.sv
interface hsv_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::HueW-1:0]    hue_degrees;
  logic [hsv2rgb_pkg::PctW-1:0]    saturation_percent;
  logic [hsv2rgb_pkg::PctW-1:0]    value_percent;

  modport source (output valid, output hue_degrees, output saturation_percent,
                  output value_percent, input ready);
  modport sink   (input valid, input hue_degrees, input saturation_percent,
                  input value_percent, output ready);
endinterface

interface rgb_if;
  logic                            valid;
  logic                            ready;
  logic [hsv2rgb_pkg::ChanW-1:0]   red;
  logic [hsv2rgb_pkg::ChanW-1:0]   green;
  logic [hsv2rgb_pkg::ChanW-1:0]   blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: hw/rtl/hsv_to_rgb_converter.sv
// hsv to rgb pixel converter. a pixel arrives as hue in whole degrees (hues of 360
// and above are reduced by 360) and saturation and value in percent (above 100
// saturates to 100); red, green and blue leave as 8-bit values, the exact rational
// result (c+m)*255 truncated toward zero. the block is a five-stage pipeline of
// hue decode, s*v products, channel mixing, a scale by 17 and a reciprocal divide
// by 625: it takes one pixel per clock while the output side is not stalled, and
// an accepted pixel is registered once in each stage in that order. each stage
// holds its own valid bit, so an empty stage keeps taking pixels while a finished
// result waits on the output; backpressure reaches every stage in the same cycle.
module hsv_to_rgb_converter (
  input  logic       clk_i,
  input  logic       rst_ni,
  hsv_if.sink        hsv_i,
  rgb_if.source      rgb_o
);

  // input transaction payload gathered into one struct
  hsv2rgb_pkg::pix_t   pix;

  // front end to mixer
  logic                front_valid;
  logic                mix_ready;
  hsv2rgb_pkg::prod_t  front_prod;

  // mixer to scaler
  logic                mix_valid;
  logic                scale_ready;
  hsv2rgb_pkg::nums_t  mix_nums;

  // scaler output register
  hsv2rgb_pkg::chans_t chans;

  assign pix.hue = hsv_i.hue_degrees;
  assign pix.sat = hsv_i.saturation_percent;
  assign pix.val = hsv_i.value_percent;

  // stages 1-2: wrap and decode hue, clamp percents, s*v and v*6000
  hsv2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hsv_i.valid),
    .in_ready_o  (hsv_i.ready),
    .in_pix_i    (pix),
    .out_valid_o (front_valid),
    .out_ready_i (mix_ready),
    .out_prod_o  (front_prod)
  );

  // stage 3: chroma, tent term and offset placed per sextant
  hsv2rgb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (mix_ready),
    .in_prod_i   (front_prod),
    .out_valid_o (mix_valid),
    .out_ready_i (scale_ready),
    .out_nums_o  (mix_nums)
  );

  // stages 4-5: truncating scale to 8 bits, last stage is the output register
  hsv2rgb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mix_valid),
    .in_ready_o  (scale_ready),
    .in_nums_i   (mix_nums),
    .out_valid_o (rgb_o.valid),
    .out_ready_i (rgb_o.ready),
    .out_chans_o (chans)
  );

  assign rgb_o.red   = chans[hsv2rgb_pkg::ChRed];
  assign rgb_o.green = chans[hsv2rgb_pkg::ChGreen];
  assign rgb_o.blue  = chans[hsv2rgb_pkg::ChBlue];

endmodule

// File: hw/rtl/hsv2rgb_front.sv
// hue decode and saturation/value products, two stages
module hsv2rgb_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv2rgb_pkg::pix_t  in_pix_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsv2rgb_pkg::prod_t out_prod_o
);

  logic                               s1_valid_q;
  logic                               s2_valid_q;
  logic                               s2_ready;
  hsv2rgb_pkg::dec_t                  s1_d, s1_q;
  hsv2rgb_pkg::prod_t                 s2_d, s2_q;
  logic [hsv2rgb_pkg::HueW-1:0]       hue_w;
  logic [hsv2rgb_pkg::HueW-1:0]       base;
  logic [hsv2rgb_pkg::TentW-1:0]      frac;
  hsv2rgb_pkg::sextant_e              sext;

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;

  // stage 1: wrap hue, find sextant, tent position, clamp percents
  always_comb begin
    hue_w = (in_pix_i.hue >= hsv2rgb_pkg::HueW'(hsv2rgb_pkg::Circle))
          ? in_pix_i.hue - hsv2rgb_pkg::HueW'(hsv2rgb_pkg::Circle) : in_pix_i.hue;
    if (hue_w < hsv2rgb_pkg::HueW'(hsv2rgb_pkg::Sextant)) begin
      sext = hsv2rgb_pkg::SEXT_RY;
    end else if (hue_w < hsv2rgb_pkg::HueW'(2 * hsv2rgb_pkg::Sextant)) begin
      sext = hsv2rgb_pkg::SEXT_YG;
    end else if (hue_w < hsv2rgb_pkg::HueW'(3 * hsv2rgb_pkg::Sextant)) begin
      sext = hsv2rgb_pkg::SEXT_GC;
    end else if (hue_w < hsv2rgb_pkg::HueW'(4 * hsv2rgb_pkg::Sextant)) begin
      sext = hsv2rgb_pkg::SEXT_CB;
    end else if (hue_w < hsv2rgb_pkg::HueW'(5 * hsv2rgb_pkg::Sextant)) begin
      sext = hsv2rgb_pkg::SEXT_BM;
    end else begin
      sext = hsv2rgb_pkg::SEXT_MR;
    end
    case (sext)
      hsv2rgb_pkg::SEXT_RY: base = '0;
      hsv2rgb_pkg::SEXT_YG: base = hsv2rgb_pkg::HueW'(hsv2rgb_pkg::Sextant);
      hsv2rgb_pkg::SEXT_GC: base = hsv2rgb_pkg::HueW'(2 * hsv2rgb_pkg::Sextant);
      hsv2rgb_pkg::SEXT_CB: base = hsv2rgb_pkg::HueW'(3 * hsv2rgb_pkg::Sextant);
      hsv2rgb_pkg::SEXT_BM: base = hsv2rgb_pkg::HueW'(4 * hsv2rgb_pkg::Sextant);
      default:              base = hsv2rgb_pkg::HueW'(5 * hsv2rgb_pkg::Sextant);
    endcase
    frac = hsv2rgb_pkg::TentW'(hue_w - base);
    s1_d.sextant = sext;
    // falling edge of the tent in odd sextants
    if (sext == hsv2rgb_pkg::SEXT_YG || sext == hsv2rgb_pkg::SEXT_CB ||
        sext == hsv2rgb_pkg::SEXT_MR) begin
      s1_d.tent = hsv2rgb_pkg::TentW'(hsv2rgb_pkg::Sextant) - frac;
    end else begin
      s1_d.tent = frac;
    end
    s1_d.sat = (in_pix_i.sat > hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctMax))
             ? hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctMax) : in_pix_i.sat;
    s1_d.val = (in_pix_i.val > hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctMax))
             ? hsv2rgb_pkg::PctW'(hsv2rgb_pkg::PctMax) : in_pix_i.val;
  end

  // stage 2: s*v and v*6000
  always_comb begin
    s2_d.sextant = s1_q.sextant;
    s2_d.tent    = s1_q.tent;
    s2_d.sv      = hsv2rgb_pkg::SvW'(s1_q.sat) * hsv2rgb_pkg::SvW'(s1_q.val);
    s2_d.v_num   = hsv2rgb_pkg::NumW'(s1_q.val) * hsv2rgb_pkg::NumW'(hsv2rgb_pkg::ValScale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_q <= s1_d;
    end
    if (s2_ready && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_prod_o  = s2_q;

endmodule

// File: hw/rtl/hsv2rgb_mix.sv
// chroma, tent term and offset placed on the three channels
module hsv2rgb_mix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  hsv2rgb_pkg::prod_t in_prod_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output hsv2rgb_pkg::nums_t out_nums_o
);

  logic                          valid_q;
  hsv2rgb_pkg::nums_t            nums_d, nums_q;
  logic [hsv2rgb_pkg::NumW-1:0]  nc, nx, nm;

  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    nc = hsv2rgb_pkg::NumW'(in_prod_i.sv) * hsv2rgb_pkg::NumW'(hsv2rgb_pkg::Sextant);
    nx = hsv2rgb_pkg::NumW'(in_prod_i.sv) * hsv2rgb_pkg::NumW'(in_prod_i.tent);
    nm = in_prod_i.v_num - nc;
    nums_d = '0;
    case (in_prod_i.sextant)
      hsv2rgb_pkg::SEXT_RY: begin
        nums_d[hsv2rgb_pkg::ChRed]   = nm + nc;
        nums_d[hsv2rgb_pkg::ChGreen] = nm + nx;
        nums_d[hsv2rgb_pkg::ChBlue]  = nm;
      end
      hsv2rgb_pkg::SEXT_YG: begin
        nums_d[hsv2rgb_pkg::ChRed]   = nm + nx;
        nums_d[hsv2rgb_pkg::ChGreen] = nm + nc;
        nums_d[hsv2rgb_pkg::ChBlue]  = nm;
      end
      hsv2rgb_pkg::SEXT_GC: begin
        nums_d[hsv2rgb_pkg::ChRed]   = nm;
        nums_d[hsv2rgb_pkg::ChGreen] = nm + nc;
        nums_d[hsv2rgb_pkg::ChBlue]  = nm + nx;
      end
      hsv2rgb_pkg::SEXT_CB: begin
        nums_d[hsv2rgb_pkg::ChRed]   = nm;
        nums_d[hsv2rgb_pkg::ChGreen] = nm + nx;
        nums_d[hsv2rgb_pkg::ChBlue]  = nm + nc;
      end
      hsv2rgb_pkg::SEXT_BM: begin
        nums_d[hsv2rgb_pkg::ChRed]   = nm + nx;
        nums_d[hsv2rgb_pkg::ChGreen] = nm;
        nums_d[hsv2rgb_pkg::ChBlue]  = nm + nc;
      end
      default: begin
        nums_d[hsv2rgb_pkg::ChRed]   = nm + nc;
        nums_d[hsv2rgb_pkg::ChGreen] = nm;
        nums_d[hsv2rgb_pkg::ChBlue]  = nm + nx;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      nums_q <= nums_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_nums_o  = nums_q;

endmodule

// File: hw/rtl/hsv2rgb_scale.sv
// scale numerators by 255/600000 with truncation, two stages
module hsv2rgb_scale (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hsv2rgb_pkg::nums_t  in_nums_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output hsv2rgb_pkg::chans_t out_chans_o
);

  logic                           s1_valid_q;
  logic                           s2_valid_q;
  logic                           s2_ready;
  hsv2rgb_pkg::reds_t             red_d, red_q;
  hsv2rgb_pkg::chans_t            chan_d, chan_q;
  logic [hsv2rgb_pkg::MulW-1:0]   mul17  [hsv2rgb_pkg::NumCh];
  logic [hsv2rgb_pkg::ProdW-1:0]  prod   [hsv2rgb_pkg::NumCh];

  assign s2_ready   = !s2_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s2_ready;

  always_comb begin
    for (int unsigned i = 0; i < hsv2rgb_pkg::NumCh; i++) begin
      // x*17, then drop the power-of-two part of 40000
      mul17[i] = hsv2rgb_pkg::MulW'(in_nums_i[i]) * hsv2rgb_pkg::MulW'(hsv2rgb_pkg::ScaleMul);
      red_d[i] = mul17[i][hsv2rgb_pkg::MulW-1:hsv2rgb_pkg::ScaleShift];
      // remaining divide by 625
      prod[i]   = hsv2rgb_pkg::ProdW'(red_q[i]) * hsv2rgb_pkg::ProdW'(hsv2rgb_pkg::RecipM);
      chan_d[i] = prod[i][hsv2rgb_pkg::RecipShift +: hsv2rgb_pkg::ChanW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      red_q <= red_d;
    end
    if (s2_ready && s1_valid_q) begin
      chan_q <= chan_d;
    end
  end

  assign out_valid_o = s2_valid_q;
  assign out_chans_o = chan_q;

endmodule

// File: hw/rtl/hsv2rgb_checker.sv
// port-level checks for the converter
module hsv2rgb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic [hsv2rgb_pkg::ChanW-1:0] red_i,
  input logic [hsv2rgb_pkg::ChanW-1:0] green_i,
  input logic [hsv2rgb_pkg::ChanW-1:0] blue_i
);

  logic in_acc;

  assign in_acc = in_valid_i && in_ready_i;

  // stalled result keeps its valid
  a_out_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

  // stalled result keeps its payload
  a_out_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(red_i) && $stable(green_i) && $stable(blue_i))
    else $error("output payload changed while stalled");

  // a free output register means the pipeline can take a pixel
  a_ready_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input not ready although the output side drains");

  // an accepted pixel reaches the output when nothing stalls
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(in_acc, 5) && $past(out_ready_i, 1) && $past(out_ready_i, 2) &&
     $past(out_ready_i, 3) && $past(out_ready_i, 4) && $past(rst_ni, 1) &&
     $past(rst_ni, 2) && $past(rst_ni, 3) && $past(rst_ni, 4) && $past(rst_ni, 5))
    |-> out_valid_i)
    else $error("pixel did not reach the output in five cycles");

endmodule

bind hsv_to_rgb_converter hsv2rgb_checker u_hsv2rgb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (hsv_i.valid),
  .in_ready_i  (hsv_i.ready),
  .out_valid_i (rgb_o.valid),
  .out_ready_i (rgb_o.ready),
  .red_i       (rgb_o.red),
  .green_i     (rgb_o.green),
  .blue_i      (rgb_o.blue)
);

// File: bench/tb_top.sv
module tb_top;
  import hsv2rgb_pkg::*;

  // output pixel as the three channel bytes
  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  // one expected output, with the pixel that caused it for the report
  typedef struct {
    pix_t pix;
    rgb_t rgb;
  } rgb_expect_t;

  // common denominator of the exact channel arithmetic (10000 * 60)
  localparam int unsigned Denom      = ValScale * PctMax;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned FlushWait  = 20;   // pipeline is five deep
  localparam int unsigned MaxReports = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // testbench side of the handshakes, known from time zero
  logic            in_valid = 1'b0;
  logic [HueW-1:0] in_hue   = '0;
  logic [PctW-1:0] in_sat   = '0;
  logic [PctW-1:0] in_val   = '0;
  logic            out_ready = 1'b0;

  pix_t        pixel_queue[$];    // pixels waiting to be offered
  rgb_expect_t rgb_expected[$];   // predicted colours not yet seen
  int unsigned fail_count  = 0;
  int unsigned cycle_count = 0;

  hsv_if hsv ();
  rgb_if rgb ();

  assign hsv.valid              = in_valid;
  assign hsv.hue_degrees        = in_hue;
  assign hsv.saturation_percent = in_sat;
  assign hsv.value_percent      = in_val;
  assign rgb.ready              = out_ready;

  hsv_to_rgb_converter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .hsv_i  (hsv),
    .rgb_o  (rgb)
  );

  // clock and the single reset at start of run
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // exact rational conversion, all terms over the common denominator
  function automatic rgb_t hsv_to_rgb_exact(pix_t p);
    int unsigned hue, sat, val, sext_idx, frac, tent, sv;
    int unsigned chroma_num, x_num, m_num, r_num, g_num, b_num;
    sextant_e    sext;
    rgb_t        res;
    hue = p.hue;
    sat = p.sat;
    val = p.val;
    // hue past full circle folds back once, percentages clamp at hundred
    if (hue >= Circle) hue = hue - Circle;
    if (sat > PctMax) sat = PctMax;
    if (val > PctMax) val = PctMax;
    sext_idx = hue / Sextant;
    sext     = sextant_e'(sext_idx);
    frac     = hue - sext_idx * Sextant;
    // rising edge of the triangle on even sextants, falling on odd ones
    tent       = (sext_idx % 2 == 1) ? (Sextant - frac) : frac;
    sv         = sat * val;
    chroma_num = sv * Sextant;
    x_num      = sv * tent;
    m_num      = val * ValScale - chroma_num;
    case (sext)
      SEXT_RY: begin r_num = chroma_num; g_num = x_num;      b_num = 0;          end
      SEXT_YG: begin r_num = x_num;      g_num = chroma_num; b_num = 0;          end
      SEXT_GC: begin r_num = 0;          g_num = chroma_num; b_num = x_num;      end
      SEXT_CB: begin r_num = 0;          g_num = x_num;      b_num = chroma_num; end
      SEXT_BM: begin r_num = x_num;      g_num = 0;          b_num = chroma_num; end
      default: begin r_num = chroma_num; g_num = 0;          b_num = x_num;      end
    endcase
    // truncating divide of (component + m) * 255
    res.red   = ChanW'(((r_num + m_num) * Full) / Denom);
    res.green = ChanW'(((g_num + m_num) * Full) / Denom);
    res.blue  = ChanW'(((b_num + m_num) * Full) / Denom);
    return res;
  endfunction

  // sender: bursts of random length separated by random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left   = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else if (!in_valid || hsv.ready) begin
      // the offered pixel (if any) has gone, choose what comes next
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        pix_t next_pix;
        next_pix = pixel_queue.pop_front();
        in_valid <= 1'b1;
        in_hue   <= next_pix.hue;
        in_sat   <= next_pix.sat;
        in_val   <= next_pix.val;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          // roughly a third of bursts run straight into the next
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: phases of free flow, random stalls, heavy stalls and a fixed pattern
  int unsigned stall_mode = 0;
  int unsigned phase_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_mode <= 0;
      phase_left <= 0;
    end else begin
      if (phase_left == 0) begin
        phase_left <= $urandom_range(8, 80);
        stall_mode <= $urandom_range(0, 3);
      end else begin
        phase_left <= phase_left - 1;
      end
      case (stall_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (phase_left % 8 > 2);
      endcase
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hsv.valid && hsv.ready) begin
        rgb_expect_t entry;
        entry.pix.hue = hsv.hue_degrees;
        entry.pix.sat = hsv.saturation_percent;
        entry.pix.val = hsv.value_percent;
        entry.rgb     = hsv_to_rgb_exact(entry.pix);
        rgb_expected.push_back(entry);
      end
      if (rgb.valid && rgb.ready) begin
        rgb_expect_t want;
        if (rgb_expected.size() == 0) begin
          if (fail_count < MaxReports)
            $display("unexpected colour r %0d g %0d b %0d at cycle %0d",
                     rgb.red, rgb.green, rgb.blue, cycle_count);
          fail_count <= fail_count + 1;
        end else begin
          want = rgb_expected.pop_front();
          if (rgb.red !== want.rgb.red || rgb.green !== want.rgb.green ||
              rgb.blue !== want.rgb.blue) begin
            if (fail_count < MaxReports)
              $display("h %0d s %0d v %0d: expected r %0d g %0d b %0d, got r %0d g %0d b %0d",
                       want.pix.hue, want.pix.sat, want.pix.val,
                       want.rgb.red, want.rgb.green, want.rgb.blue,
                       rgb.red, rgb.green, rgb.blue);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  // watchdog on the cycle counter
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic add_pixel(int unsigned hue, int unsigned sat, int unsigned val);
    pix_t p;
    p.hue = HueW'(hue);
    p.sat = PctW'(sat);
    p.val = PctW'(val);
    pixel_queue.push_back(p);
  endtask

  // sender holds off until every transaction has come out the far side
  task automatic wait_drained();
    while (pixel_queue.size() != 0 || in_valid || rgb_expected.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic add_random_pixels(int unsigned count);
    int unsigned hue, sat, val;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: begin
          // whole field range, hue past full circle and clamped percentages
          hue = $urandom_range(0, 511);
          sat = $urandom_range(0, 127);
          val = $urandom_range(0, 127);
        end
        1: begin
          // grey pixels
          hue = $urandom_range(0, 511);
          sat = 0;
          val = $urandom_range(0, 127);
        end
        2: begin
          // close to a sextant boundary
          hue = ($urandom_range(0, 6) * Sextant + $urandom_range(0, 2) + 511) % 512;
          sat = $urandom_range(0, 100);
          val = $urandom_range(0, 100);
        end
        default: begin
          hue = $urandom_range(0, Circle - 1);
          sat = $urandom_range(0, PctMax);
          val = $urandom_range(0, PctMax);
        end
      endcase
      add_pixel(hue, sat, val);
    end
  endtask

  initial begin
    // sextant edges at full colour
    add_pixel(0, 100, 100);
    add_pixel(59, 100, 100);
    add_pixel(60, 100, 100);
    add_pixel(119, 100, 100);
    add_pixel(120, 100, 100);
    add_pixel(179, 100, 100);
    add_pixel(180, 100, 100);
    add_pixel(239, 100, 100);
    add_pixel(240, 100, 100);
    add_pixel(299, 100, 100);
    add_pixel(300, 100, 100);
    add_pixel(359, 100, 100);
    // hue past the full circle
    add_pixel(360, 100, 100);
    add_pixel(419, 80, 90);
    add_pixel(511, 100, 100);
    // percentages above hundred saturate
    add_pixel(200, 101, 127);
    add_pixel(30, 127, 101);
    // zero saturation gives grey
    add_pixel(45, 0, 100);
    add_pixel(300, 0, 37);
    add_pixel(0, 0, 0);
    // zero value and odd mid values
    add_pixel(150, 100, 0);
    add_pixel(90, 33, 67);
    add_pixel(271, 1, 1);
    add_pixel(511, 127, 127);
    add_pixel(255, 85, 42);
    wait_drained();

    // random part in two halves with a full drain between
    add_random_pixels(600);
    wait_drained();
    add_random_pixels(600);
    wait_drained();

    // let any stray output show up before the verdict
    repeat (FlushWait) @(negedge clk_i);
    if (fail_count == 0 && rgb_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
